### hw/rtl/triac_phase_angle_controller_macros.svh
// Assertion macros for the triac phase-angle controller.
`ifndef TRIAC_PHASE_ANGLE_CONTROLLER_MACROS_SVH
`define TRIAC_PHASE_ANGLE_CONTROLLER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define TPAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpac: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpac: next-cycle check failed");

`else

`define TPAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TPAC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/tpac_pkg.sv
// Shared types, codes and reset constants for the triac phase-angle controller.
package tpac_pkg;

    localparam int DELAY_BITS = 16;
    localparam int LED_COUNT  = 4;

    typedef logic [DELAY_BITS-1:0] delay_t;
    typedef logic [2:0]            mode_t;
    typedef logic [2:0]            cfg_index_t;
    typedef logic [2:0]            level_t;
    typedef logic [7:0]            pulse_t;
    typedef logic [3:0]            subcount_t;

    localparam delay_t DELAY_MAX = '1;
    localparam level_t LED_MAX   = level_t'(LED_COUNT);

    // Event codes carried in the mode field.
    localparam mode_t MODE_TIMER_TICK  = 3'd0;
    localparam mode_t MODE_ZERO_CROSS  = 3'd1;
    localparam mode_t MODE_SPEED_UP    = 3'd2;
    localparam mode_t MODE_SLOW_DOWN   = 3'd3;
    localparam mode_t MODE_SOFT_START  = 3'd4;
    localparam mode_t MODE_RAMP_TICK   = 3'd5;
    localparam mode_t MODE_LED_UP      = 3'd6;
    localparam mode_t MODE_LED_DOWN    = 3'd7;

    // Configuration register indexes.
    localparam cfg_index_t CFG_ADJUST_STEP   = 3'd0;
    localparam cfg_index_t CFG_DELAY_FLOOR   = 3'd1;
    localparam cfg_index_t CFG_DELAY_CEILING = 3'd2;
    localparam cfg_index_t CFG_RAMP_START    = 3'd3;
    localparam cfg_index_t CFG_RAMP_STEP     = 3'd4;
    localparam cfg_index_t CFG_PULSE_TICKS   = 3'd5;
    localparam cfg_index_t CFG_RAMP_PER_LED  = 3'd6;

    // Configuration reset values.
    localparam delay_t    RST_ADJUST_STEP   = 16'd1600;
    localparam delay_t    RST_DELAY_FLOOR   = 16'd600;
    localparam delay_t    RST_DELAY_CEILING = 16'd7000;
    localparam delay_t    RST_RAMP_START    = 16'd8000;
    localparam delay_t    RST_RAMP_STEP     = 16'd370;
    localparam pulse_t    RST_PULSE_TICKS   = 8'd10;
    localparam subcount_t RST_RAMP_PER_LED  = 4'd5;

    typedef struct packed {
        logic   gate_on;
        level_t led_level;
        logic   power_led;
        delay_t firing_delay;
        logic   ramping;
        logic   full_power;
    } result_t;

endpackage

### hw/rtl/tpac_if.sv
// Valid/ready channel interfaces for event words and result words.
interface tpac_in_if;
    logic                 valid;
    logic                 ready;
    tpac_pkg::mode_t      mode;
    tpac_pkg::delay_t     target;

    modport source (output valid, output mode, output target, input ready);
    modport sink   (input valid, input mode, input target, output ready);
endinterface

interface tpac_out_if;
    logic                 valid;
    logic                 ready;
    logic                 gate_on;
    tpac_pkg::level_t     led_level;
    logic                 power_led;
    tpac_pkg::delay_t     firing_delay;
    logic                 ramping;
    logic                 full_power;

    modport source (output valid, output gate_on, output led_level, output power_led,
                    output firing_delay, output ramping, output full_power, input ready);
    modport sink   (input valid, input gate_on, input led_level, input power_led,
                    input firing_delay, input ramping, input full_power, output ready);
endinterface

### hw/rtl/triac_phase_angle_controller.sv
// Phase-angle triac controller: every event word updates the state and yields one result word,
// and a new event word can be taken on every clock cycle while the result register is free.
// The state update for an accepted word is combinational and lands in the result register,
// so the result appears in the cycle after acceptance. The result register is the only stage
// between the two channels: the block keeps taking words while the result register is empty or
// drained in the same cycle, so throughput is one word per clock whenever downstream is ready.
module triac_phase_angle_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  tpac_pkg::cfg_index_t   cfg_index,
    input  tpac_pkg::delay_t       cfg_data,
    tpac_in_if.sink                evt,
    tpac_out_if.source             res
);

    `include "triac_phase_angle_controller_macros.svh"

    // Configuration registers.
    tpac_pkg::delay_t    adjust_step_reg;
    tpac_pkg::delay_t    delay_floor_reg;
    tpac_pkg::delay_t    delay_ceiling_reg;
    tpac_pkg::delay_t    ramp_start_reg;
    tpac_pkg::delay_t    ramp_step_reg;
    tpac_pkg::pulse_t    pulse_ticks_reg;
    tpac_pkg::subcount_t ramp_per_led_reg;

    // Controller state.
    tpac_pkg::delay_t    fire_delay_reg, fire_delay_next;
    tpac_pkg::delay_t    ramp_delay_reg, ramp_delay_next;
    tpac_pkg::delay_t    tick_count_reg, tick_count_next;
    tpac_pkg::delay_t    target_delay_reg, target_delay_next;
    tpac_pkg::pulse_t    pulse_left_reg, pulse_left_next;
    tpac_pkg::level_t    level_reg, level_next;
    tpac_pkg::subcount_t ramp_subcount_reg, ramp_subcount_next;
    logic                counting_reg, counting_next;
    logic                speed_up_reg, speed_up_next;
    logic                slow_down_reg, slow_down_next;
    logic                soft_active_reg, soft_active_next;
    logic                max_power_reg, max_power_next;
    logic                power_ind_reg, power_ind_next;

    // Result register.
    logic                res_valid_reg, res_valid_next;
    tpac_pkg::result_t   res_data_reg, res_data_next;

    logic                evt_fire;
    logic                res_fire;

    // Datapath helpers.
    logic [tpac_pkg::DELAY_BITS:0] down_diff;
    logic [tpac_pkg::DELAY_BITS:0] up_sum;
    tpac_pkg::delay_t    step_down_val;
    tpac_pkg::delay_t    step_up_val;
    tpac_pkg::delay_t    tick_inc;
    tpac_pkg::delay_t    ramp_dec;
    tpac_pkg::subcount_t sub_inc;
    logic                led_up_ok;
    logic                led_down_ok;

    assign res_fire  = res_valid_reg && res.ready;
    assign evt.ready = !res_valid_reg || res.ready;
    assign evt_fire  = evt.valid && evt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adjust_step_reg   <= tpac_pkg::RST_ADJUST_STEP;
            delay_floor_reg   <= tpac_pkg::RST_DELAY_FLOOR;
            delay_ceiling_reg <= tpac_pkg::RST_DELAY_CEILING;
            ramp_start_reg    <= tpac_pkg::RST_RAMP_START;
            ramp_step_reg     <= tpac_pkg::RST_RAMP_STEP;
            pulse_ticks_reg   <= tpac_pkg::RST_PULSE_TICKS;
            ramp_per_led_reg  <= tpac_pkg::RST_RAMP_PER_LED;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpac_pkg::CFG_ADJUST_STEP:   adjust_step_reg   <= cfg_data;
                tpac_pkg::CFG_DELAY_FLOOR:   delay_floor_reg   <= cfg_data;
                tpac_pkg::CFG_DELAY_CEILING: delay_ceiling_reg <= cfg_data;
                tpac_pkg::CFG_RAMP_START:    ramp_start_reg    <= cfg_data;
                tpac_pkg::CFG_RAMP_STEP:     ramp_step_reg     <= cfg_data;
                tpac_pkg::CFG_PULSE_TICKS:   pulse_ticks_reg   <= cfg_data[7:0];
                tpac_pkg::CFG_RAMP_PER_LED:  ramp_per_led_reg  <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // A speed-up step that would borrow or drop below the floor lands on the floor.
    assign down_diff     = {1'b0, fire_delay_reg} - {1'b0, adjust_step_reg};
    assign step_down_val = (!down_diff[tpac_pkg::DELAY_BITS] &&
                            (down_diff[tpac_pkg::DELAY_BITS-1:0] >= delay_floor_reg))
                           ? down_diff[tpac_pkg::DELAY_BITS-1:0] : delay_floor_reg;

    // A slow-down step is clipped at the ceiling; the sum keeps its carry bit.
    assign up_sum      = {1'b0, fire_delay_reg} + {1'b0, adjust_step_reg};
    assign step_up_val = (up_sum > {1'b0, delay_ceiling_reg})
                         ? delay_ceiling_reg : up_sum[tpac_pkg::DELAY_BITS-1:0];

    assign tick_inc = (tick_count_reg != tpac_pkg::DELAY_MAX)
                      ? tick_count_reg + 1'b1 : tick_count_reg;
    assign ramp_dec = (ramp_delay_reg >= ramp_step_reg)
                      ? ramp_delay_reg - ramp_step_reg : '0;
    assign sub_inc  = ramp_subcount_reg + 1'b1;

    assign led_up_ok   = (level_reg < tpac_pkg::LED_MAX) && (ramp_delay_reg >= delay_floor_reg);
    assign led_down_ok = (level_reg != '0) && (ramp_delay_reg <= delay_ceiling_reg);

    always_comb
    begin
        fire_delay_next    = fire_delay_reg;
        ramp_delay_next    = ramp_delay_reg;
        tick_count_next    = tick_count_reg;
        target_delay_next  = target_delay_reg;
        pulse_left_next    = pulse_left_reg;
        level_next         = level_reg;
        ramp_subcount_next = ramp_subcount_reg;
        counting_next      = counting_reg;
        speed_up_next      = speed_up_reg;
        slow_down_next     = slow_down_reg;
        soft_active_next   = soft_active_reg;
        max_power_next     = max_power_reg;
        power_ind_next     = power_ind_reg;

        if (evt_fire)
        begin
            unique case (evt.mode)
                tpac_pkg::MODE_TIMER_TICK:
                begin
                    if (pulse_left_reg != '0)
                    begin
                        pulse_left_next = pulse_left_reg - 1'b1;
                    end
                    if (counting_reg)
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= fire_delay_reg)
                        begin
                            counting_next   = 1'b0;
                            pulse_left_next = pulse_ticks_reg;
                        end
                    end
                end
                tpac_pkg::MODE_ZERO_CROSS:
                begin
                    if (soft_active_reg)
                    begin
                        fire_delay_next = ramp_delay_reg;
                    end
                    else if (speed_up_reg)
                    begin
                        if ((fire_delay_reg > delay_floor_reg) &&
                            (fire_delay_reg > target_delay_reg))
                        begin
                            fire_delay_next = step_down_val;
                        end
                        else
                        begin
                            speed_up_next = 1'b0;
                        end
                    end
                    else if (slow_down_reg)
                    begin
                        if ((fire_delay_reg < delay_ceiling_reg) &&
                            (fire_delay_reg < target_delay_reg))
                        begin
                            fire_delay_next = step_up_val;
                        end
                        else
                        begin
                            slow_down_next = 1'b0;
                        end
                    end
                    tick_count_next = '0;
                    counting_next   = 1'b1;
                end
                tpac_pkg::MODE_SPEED_UP:
                begin
                    speed_up_next     = 1'b1;
                    slow_down_next    = 1'b0;
                    target_delay_next = evt.target;
                end
                tpac_pkg::MODE_SLOW_DOWN:
                begin
                    slow_down_next    = 1'b1;
                    speed_up_next     = 1'b0;
                    target_delay_next = evt.target;
                end
                tpac_pkg::MODE_SOFT_START:
                begin
                    power_ind_next     = 1'b1;
                    ramp_subcount_next = '0;
                    ramp_delay_next    = ramp_start_reg;
                    // A ramp that already starts at the floor goes straight to full power.
                    if (ramp_start_reg <= delay_floor_reg)
                    begin
                        soft_active_next = 1'b0;
                        max_power_next   = 1'b1;
                    end
                    else
                    begin
                        soft_active_next = 1'b1;
                        max_power_next   = 1'b0;
                    end
                end
                tpac_pkg::MODE_RAMP_TICK:
                begin
                    if (soft_active_reg)
                    begin
                        ramp_subcount_next = sub_inc;
                        // The LED check sees the ramp delay from before this tick's step.
                        if (sub_inc >= ramp_per_led_reg)
                        begin
                            ramp_subcount_next = '0;
                            if (led_up_ok)
                            begin
                                level_next = level_reg + 1'b1;
                            end
                        end
                        ramp_delay_next = ramp_dec;
                        if (ramp_dec <= delay_floor_reg)
                        begin
                            soft_active_next = 1'b0;
                            max_power_next   = 1'b1;
                        end
                    end
                end
                tpac_pkg::MODE_LED_UP:
                begin
                    if (led_up_ok)
                    begin
                        level_next = level_reg + 1'b1;
                    end
                end
                tpac_pkg::MODE_LED_DOWN:
                begin
                    if (led_down_ok)
                    begin
                        level_next = level_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (evt_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_fire)
        begin
            res_valid_next = 1'b0;
        end

        res_data_next              = res_data_reg;
        if (evt_fire)
        begin
            res_data_next.gate_on      = max_power_next || (pulse_left_next != '0);
            res_data_next.led_level    = level_next;
            res_data_next.power_led    = power_ind_next;
            res_data_next.firing_delay = fire_delay_next;
            res_data_next.ramping      = soft_active_next;
            res_data_next.full_power   = max_power_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fire_delay_reg    <= tpac_pkg::RST_DELAY_FLOOR;
            target_delay_reg  <= tpac_pkg::RST_DELAY_FLOOR;
            ramp_delay_reg    <= '0;
            tick_count_reg    <= '0;
            pulse_left_reg    <= '0;
            level_reg         <= '0;
            ramp_subcount_reg <= '0;
            counting_reg      <= 1'b0;
            speed_up_reg      <= 1'b0;
            slow_down_reg     <= 1'b0;
            soft_active_reg   <= 1'b0;
            max_power_reg     <= 1'b0;
            power_ind_reg     <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            fire_delay_reg    <= fire_delay_next;
            target_delay_reg  <= target_delay_next;
            ramp_delay_reg    <= ramp_delay_next;
            tick_count_reg    <= tick_count_next;
            pulse_left_reg    <= pulse_left_next;
            level_reg         <= level_next;
            ramp_subcount_reg <= ramp_subcount_next;
            counting_reg      <= counting_next;
            speed_up_reg      <= speed_up_next;
            slow_down_reg     <= slow_down_next;
            soft_active_reg   <= soft_active_next;
            max_power_reg     <= max_power_next;
            power_ind_reg     <= power_ind_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res.valid        = res_valid_reg;
    assign res.gate_on      = res_data_reg.gate_on;
    assign res.led_level    = res_data_reg.led_level;
    assign res.power_led    = res_data_reg.power_led;
    assign res.firing_delay = res_data_reg.firing_delay;
    assign res.ramping      = res_data_reg.ramping;
    assign res.full_power   = res_data_reg.full_power;

    // Soft start and full power never hold together.
    `TPAC_ASSERT_IMP(a_soft_excl_full, clk, rst_n, max_power_reg, !soft_active_reg)
    // Every accepted word leaves a result waiting in the next cycle.
    `TPAC_ASSERT_NXT(a_word_gives_result, clk, rst_n, evt_fire, res_valid_reg)
    // The LED level never goes past the number of LEDs.
    `TPAC_ASSERT_IMP(a_level_bound, clk, rst_n, 1'b1, level_reg <= tpac_pkg::LED_MAX)
    // A speed-up and a slow-down request are never pending together.
    `TPAC_ASSERT_IMP(a_one_request, clk, rst_n, speed_up_reg, !slow_down_reg)

endmodule
